// ===== design/scph_pkg.sv =====
// Package for the segment / convex polygon hit test.
// Holds opcodes, the sequencer state type and fixed-point constants.
// No dependencies.
package scph_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CROSS,
      ST_CLIP,
      ST_DIVIDE,
      ST_UPDATE,
      ST_MID_READ,
      ST_MID_CROSS,
      ST_MID_MUL,
      ST_MID_TEST,
      ST_DONE
   } state_type;

   // Q1.30 parameter range
   localparam int T_BITS = 31;
   localparam logic [T_BITS-1:0] T_ONE = 31'h4000_0000;
   localparam int FRAC_STEPS = 30;

endpackage

// ===== design/scph_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module scph_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/scph_divider.sv =====
// Restoring fraction divider: floor(num * 2^30 / den) for 0 <= num < den.
// One quotient bit per cycle. Depends on scph_pkg.
module scph_divider #(
   parameter int VAL_BITS = 50
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [VAL_BITS-1:0]         num,
   input  logic [VAL_BITS-1:0]         den,
   output logic                        done,
   output logic [scph_pkg::T_BITS-1:0] quotient
);

   logic [VAL_BITS:0]               rem_ff, rem_in;
   logic [VAL_BITS-1:0]             den_ff, den_in;
   logic [scph_pkg::T_BITS-1:0]     quo_ff, quo_in;
   logic [4:0]                      cnt_ff, cnt_in;
   logic                            run_ff, run_in;
   logic                            done_ff, done_in;
   logic [VAL_BITS:0]               shifted;

   assign shifted = {rem_ff[VAL_BITS-1:0], 1'b0};

   // step one quotient bit
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = {1'b0, num};
         den_in = den;
         quo_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[scph_pkg::T_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[scph_pkg::T_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(scph_pkg::FRAC_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/segment_convex_polygon_hit.sv =====
// Top level of the segment / convex polygon interior hit test.
// Depends on scph_pkg, scph_ram and scph_divider.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  request | req_opcode, req_first_*, req_second_*   | start & !busy
//  result  | rsp_hits_interior                       | rsp_valid, one cycle
//
// Clear and append are handled in the idle state. A query walks the edges,
// reading both corners, forming cross products and clipping t, and runs the
// bit-serial divider when an edge clips t below 1; a second walk over the
// edges then tests the midpoint. reset is synchronous and clears count, box
// and sequencer. Results cannot be stalled.
module segment_convex_polygon_hit #(
   parameter int MAX_CORNERS = 16,
   parameter int COORD_BITS  = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic signed [COORD_BITS-1:0] req_first_x,
   input  logic signed [COORD_BITS-1:0] req_first_y,
   input  logic signed [COORD_BITS-1:0] req_second_x,
   input  logic signed [COORD_BITS-1:0] req_second_y,
   output logic                  rsp_valid,
   output logic                  rsp_hits_interior
);

   localparam int IDX_BITS  = $clog2(MAX_CORNERS);
   localparam int CNT_BITS  = $clog2(MAX_CORNERS + 1);
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS + 1;
   localparam int T_BITS    = scph_pkg::T_BITS;
   localparam int M_BITS    = T_BITS + 1;
   localparam int CMP_BITS  = PROD_BITS + M_BITS + 1;
   localparam int LO_BITS   = DIFF_BITS;
   localparam int HI_BITS   = PROD_BITS - LO_BITS;
   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   scph_pkg::state_type state_ff, state_in;

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic signed [COORD_BITS-1:0] bminx_ff, bminx_in, bmaxx_ff, bmaxx_in;
   logic signed [COORD_BITS-1:0] bminy_ff, bminy_in, bmaxy_ff, bmaxy_in;
   logic signed [COORD_BITS-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [IDX_BITS-1:0] edge_ff, edge_in;
   logic                second_ff, second_in;
   logic [T_BITS-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic signed [PROD_BITS-1:0] av_ff, bv_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                hit_ff, hit_in;
   logic signed [CMP_BITS-1:0] lhs_ff;
   logic [M_BITS+LO_BITS-1:0]  mul_lo_ff;
   logic signed [M_BITS+HI_BITS:0] mul_hi_ff;
   logic                div_start;
   logic                div_done;
   logic [T_BITS-1:0]   div_q;
   logic                accept;

   // corner memory: x in high half, y in low half; two reads per edge
   logic                     ram_we;
   logic [IDX_BITS-1:0]      ram_waddr, ram_raddr;
   logic [2*COORD_BITS-1:0]  ram_rdata;
   logic                     phase_ff, phase_in;

   scph_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_CORNERS)) u_corners (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({req_first_x, req_first_y}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign accept    = start && !busy;
   assign ram_we    = accept && (req_opcode == scph_pkg::OP_APPEND) &&
                      (count_ff < CNT_BITS'(MAX_CORNERS));
   assign ram_waddr = count_ff[IDX_BITS-1:0];

   // next vertex index with wrap
   logic [IDX_BITS-1:0] next_idx;
   assign next_idx = (CNT_BITS'(edge_ff) + 1'b1 == count_ff) ? '0 : edge_ff + 1'b1;
   assign ram_raddr = phase_ff ? next_idx : edge_ff;

   // edge vector and cross products
   logic signed [COORD_BITS-1:0] qx, qy;
   logic signed [DIFF_BITS-1:0] ex, ey, sx, sy, dx, dy;
   logic signed [2*DIFF_BITS-1:0] es_p, ys_p, ed_p, yd_p;
   logic signed [PROD_BITS-1:0] av_c, bv_c;
   assign qx = ram_rdata[2*COORD_BITS-1:COORD_BITS];
   assign qy = ram_rdata[COORD_BITS-1:0];
   assign ex = DIFF_BITS'(qx) - DIFF_BITS'(px_ff);
   assign ey = DIFF_BITS'(qy) - DIFF_BITS'(py_ff);
   assign sx = DIFF_BITS'(ax_ff) - DIFF_BITS'(px_ff);
   assign sy = DIFF_BITS'(ay_ff) - DIFF_BITS'(py_ff);
   assign dx = DIFF_BITS'(bx_ff) - DIFF_BITS'(ax_ff);
   assign dy = DIFF_BITS'(by_ff) - DIFF_BITS'(ay_ff);
   assign es_p = ex * sy;
   assign ys_p = ey * sx;
   assign ed_p = ex * dy;
   assign yd_p = ey * dx;
   assign av_c = PROD_BITS'(es_p) - PROD_BITS'(ys_p);
   assign bv_c = PROD_BITS'(ed_p) - PROD_BITS'(yd_p);

   // clipping numerator and denominator
   logic signed [PROD_BITS-1:0] num_s, den_s;
   logic [PROD_BITS-1:0] num_u, den_u;
   assign num_s = (bv_ff < 0) ? av_ff : -av_ff;
   assign den_s = (bv_ff < 0) ? -bv_ff : bv_ff;
   assign num_u = PROD_BITS'(num_s);
   assign den_u = PROD_BITS'(den_s);

   scph_divider #(.VAL_BITS(PROD_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_u),
      .den      (den_u),
      .done     (div_done),
      .quotient (div_q)
   );

   // midpoint test operands: A*2^31 vs -(m*B)
   logic [M_BITS-1:0] mid;
   assign mid = M_BITS'(lo_ff) + M_BITS'(hi_ff);

   // split B into a low unsigned part and a high signed part for two products
   logic [LO_BITS-1:0]             bv_lo;
   logic signed [HI_BITS-1:0]      bv_hi;
   logic [M_BITS+LO_BITS-1:0]      mul_lo_c;
   logic signed [M_BITS+HI_BITS:0] mul_hi_c;
   logic signed [CMP_BITS-1:0]     mid_sum;
   assign bv_lo    = bv_ff[LO_BITS-1:0];
   assign bv_hi    = bv_ff[PROD_BITS-1:LO_BITS];
   assign mul_lo_c = mid * bv_lo;
   assign mul_hi_c = $signed({1'b0, mid}) * bv_hi;
   assign mid_sum  = lhs_ff + (CMP_BITS'(mul_hi_ff) <<< LO_BITS) +
                     CMP_BITS'($signed({1'b0, mul_lo_ff}));

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scph_pkg::ST_IDLE: begin
            if (accept && req_opcode == scph_pkg::OP_QUERY) begin
               state_in = scph_pkg::ST_READ;
            end
         end
         scph_pkg::ST_READ: begin
            if (phase_ff) begin
               state_in = second_ff ? scph_pkg::ST_MID_CROSS : scph_pkg::ST_CROSS;
            end
         end
         scph_pkg::ST_CROSS:     state_in = scph_pkg::ST_CLIP;
         scph_pkg::ST_CLIP: begin
            if (bv_ff == '0) begin
               state_in = (av_ff < 0) ? scph_pkg::ST_DONE : scph_pkg::ST_UPDATE;
            end else if (bv_ff > 0) begin
               if (num_s > den_s) state_in = scph_pkg::ST_DONE;
               else if (num_s >= 0) state_in = scph_pkg::ST_DIVIDE;
               else state_in = scph_pkg::ST_UPDATE;
            end else begin
               if (num_s < 0) state_in = scph_pkg::ST_DONE;
               else if (num_s <= den_s) state_in = scph_pkg::ST_DIVIDE;
               else state_in = scph_pkg::ST_UPDATE;
            end
         end
         scph_pkg::ST_DIVIDE: begin
            if (div_done) state_in = scph_pkg::ST_UPDATE;
         end
         scph_pkg::ST_UPDATE: begin
            if (lo_ff > hi_ff) state_in = scph_pkg::ST_DONE;
            else state_in = scph_pkg::ST_READ;
         end
         scph_pkg::ST_MID_READ:  state_in = scph_pkg::ST_READ;
         scph_pkg::ST_MID_CROSS: state_in = scph_pkg::ST_MID_MUL;
         scph_pkg::ST_MID_MUL:   state_in = scph_pkg::ST_MID_TEST;
         scph_pkg::ST_MID_TEST: begin
            if (mid_sum <= 0) state_in = scph_pkg::ST_DONE;
            else if (CNT_BITS'(edge_ff) + 1'b1 == count_ff) state_in = scph_pkg::ST_DONE;
            else state_in = scph_pkg::ST_READ;
         end
         scph_pkg::ST_DONE:      state_in = scph_pkg::ST_IDLE;
         default:                state_in = scph_pkg::ST_IDLE;
      endcase
      // early answers on entry
      if (state_ff == scph_pkg::ST_IDLE && state_in == scph_pkg::ST_READ) begin
         if (count_ff < CNT_BITS'(3) ||
             (req_first_x > req_second_x ? req_first_x : req_second_x) < bminx_ff ||
             (req_first_x < req_second_x ? req_first_x : req_second_x) > bmaxx_ff ||
             (req_first_y > req_second_y ? req_first_y : req_second_y) < bminy_ff ||
             (req_first_y < req_second_y ? req_first_y : req_second_y) > bmaxy_ff) begin
            state_in = scph_pkg::ST_DONE;
         end
      end
   end

   // datapath and outputs
   always_comb begin
      count_in     = count_ff;
      bminx_in     = bminx_ff;
      bmaxx_in     = bmaxx_ff;
      bminy_in     = bminy_ff;
      bmaxy_in     = bmaxy_ff;
      edge_in      = edge_ff;
      second_in    = second_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      phase_in     = 1'b0;
      rsp_valid_in = 1'b0;
      hit_in       = hit_ff;
      div_start    = 1'b0;
      case (state_ff)
         scph_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  scph_pkg::OP_CLEAR: begin
                     count_in = '0;
                     bminx_in = C_MAX;
                     bminy_in = C_MAX;
                     bmaxx_in = C_MIN;
                     bmaxy_in = C_MIN;
                  end
                  scph_pkg::OP_APPEND: begin
                     if (ram_we) begin
                        count_in = count_ff + 1'b1;
                        if (req_first_x < bminx_ff) bminx_in = req_first_x;
                        if (req_first_x > bmaxx_ff) bmaxx_in = req_first_x;
                        if (req_first_y < bminy_ff) bminy_in = req_first_y;
                        if (req_first_y > bmaxy_ff) bmaxy_in = req_first_y;
                     end
                  end
                  scph_pkg::OP_QUERY: begin
                     edge_in   = '0;
                     second_in = 1'b0;
                     lo_in     = '0;
                     hi_in     = scph_pkg::T_ONE;
                     hit_in    = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         scph_pkg::ST_READ:  phase_in = !phase_ff;
         scph_pkg::ST_CLIP: begin
            if (state_in == scph_pkg::ST_DIVIDE) begin
               if (num_u >= den_u) begin
                  if (bv_ff > 0) begin
                     if (scph_pkg::T_ONE > lo_ff) lo_in = scph_pkg::T_ONE;
                  end
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         scph_pkg::ST_DIVIDE: begin
            if (div_done) begin
               if (bv_ff > 0) begin
                  if (div_q > lo_ff) lo_in = div_q;
               end else begin
                  if (div_q < hi_ff) hi_in = div_q;
               end
            end
         end
         scph_pkg::ST_UPDATE: begin
            if (lo_ff <= hi_ff) begin
               if (CNT_BITS'(edge_ff) + 1'b1 == count_ff) begin
                  edge_in   = '0;
                  second_in = 1'b1;
               end else begin
                  edge_in = edge_ff + 1'b1;
               end
            end
         end
         scph_pkg::ST_MID_TEST: begin
            if (mid_sum > 0) begin
               if (CNT_BITS'(edge_ff) + 1'b1 == count_ff) hit_in = 1'b1;
               else edge_in = edge_ff + 1'b1;
            end
         end
         scph_pkg::ST_DONE:  rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   // divider result when numerator equals denominator: skip the wait
   logic div_full;
   assign div_full = (state_ff == scph_pkg::ST_CLIP) && (state_in == scph_pkg::ST_DIVIDE) &&
                     (num_u >= den_u);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scph_pkg::ST_IDLE;
         count_ff     <= '0;
         bminx_ff     <= C_MAX;
         bminy_ff     <= C_MAX;
         bmaxx_ff     <= C_MIN;
         bmaxy_ff     <= C_MIN;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= div_full ? scph_pkg::ST_UPDATE : state_in;
         count_ff     <= count_in;
         bminx_ff     <= bminx_in;
         bminy_ff     <= bminy_in;
         bmaxx_ff     <= bmaxx_in;
         bmaxy_ff     <= bmaxy_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      edge_ff   <= edge_in;
      second_ff <= second_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      hit_ff    <= hit_in;
      if (accept) begin
         ax_ff <= req_first_x;
         ay_ff <= req_first_y;
         bx_ff <= req_second_x;
         by_ff <= req_second_y;
      end
      // first read returns vertex p
      if (state_ff == scph_pkg::ST_READ && phase_ff) begin
         px_ff <= qx;
         py_ff <= qy;
      end
      if (state_ff == scph_pkg::ST_CROSS || state_ff == scph_pkg::ST_MID_CROSS) begin
         av_ff <= av_c;
         bv_ff <= bv_c;
      end
      // A*2^31 and m*B as two partial products; strict inside when the sum is positive
      if (state_ff == scph_pkg::ST_MID_MUL) begin
         lhs_ff    <= CMP_BITS'(av_ff) <<< 31;
         mul_lo_ff <= mul_lo_c;
         mul_hi_ff <= mul_hi_c;
      end
   end

   // cross step reads q on the phase after p
   assign busy              = (state_ff != scph_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hits_interior = hit_ff;

`ifndef SYNTHESIS
   // a result only follows the done state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == scph_pkg::ST_DONE))
      else $error("result without done state");
   // the clipped interval never leaves [0,1]
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == scph_pkg::ST_MID_TEST) |-> (hi_ff <= scph_pkg::T_ONE && lo_ff <= hi_ff))
      else $error("clip interval out of range");
   // corner count never exceeds the memory depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_CORNERS))
      else $error("corner count overflow");
`endif

endmodule

// ===== test/scph_checker.sv =====
// Checker for the segment / convex polygon hit test: watches both channels,
// predicts each query answer and compares it with the block's result.
// Depends on scph_pkg.
`timescale 1ns / 1ps
module scph_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic signed [23:0] req_first_x,
   input  logic signed [23:0] req_first_y,
   input  logic signed [23:0] req_second_x,
   input  logic signed [23:0] req_second_y,
   input  logic        rsp_valid,
   input  logic        rsp_hits_interior,
   output int          fail_count,
   output int          pending_count
);

   localparam int CORNER_MAX = 16;
   localparam longint COORD_TOP = 64'sd8388607;
   localparam longint COORD_BOTTOM = -64'sd8388608;
   localparam longint T_UNIT = 64'sd1073741824;

   longint poly_x[CORNER_MAX];
   longint poly_y[CORNER_MAX];
   int     poly_count;
   longint bb_min_x, bb_max_x, bb_min_y, bb_max_y;
   bit     hit_answers[$];

   // floor(num * 2^30 / den) for 0 <= num <= den
   function automatic longint t_quotient(longint num, longint den);
      logic [127:0] wide;
      if (num >= den) return T_UNIT;
      wide = 128'(num) << 30;
      return longint'(wide / 128'(den));
   endfunction

   // exact sign of a*2^31 + m*b > 0
   function automatic bit mid_strictly_inside(longint a, longint b, longint m);
      logic signed [127:0] total;
      total = ($signed(128'(a)) <<< 31) + $signed(128'(m)) * $signed(128'(b));
      return total > 0;
   endfunction

   function automatic bit segment_hits(longint ax, longint ay, longint bx, longint by);
      longint dx, dy, lo, hi, ex, ey, av, bv, num, den, t;
      int j;
      dx = bx - ax;
      dy = by - ay;
      lo = 0;
      hi = T_UNIT;
      if (poly_count < 3) return 0;
      if ((ax > bx ? ax : bx) < bb_min_x || (ax < bx ? ax : bx) > bb_max_x) return 0;
      if ((ay > by ? ay : by) < bb_min_y || (ay < by ? ay : by) > bb_max_y) return 0;
      // clip t against every edge
      for (int i = 0; i < poly_count; i++) begin
         j = (i + 1 == poly_count) ? 0 : i + 1;
         ex = poly_x[j] - poly_x[i];
         ey = poly_y[j] - poly_y[i];
         av = ex * (ay - poly_y[i]) - ey * (ax - poly_x[i]);
         bv = ex * dy - ey * dx;
         if (bv == 0) begin
            if (av < 0) return 0;
            continue;
         end
         num = -av;
         den = bv;
         if (den < 0) begin
            num = -num;
            den = -den;
         end
         if (bv > 0) begin
            if (num > den) return 0;
            if (num >= 0) begin
               t = t_quotient(num, den);
               if (t > lo) lo = t;
            end
         end else begin
            if (num < 0) return 0;
            if (num <= den) begin
               t = t_quotient(num, den);
               if (t < hi) hi = t;
            end
         end
         if (lo > hi) return 0;
      end
      // midpoint must be strictly inside every edge
      for (int i = 0; i < poly_count; i++) begin
         j = (i + 1 == poly_count) ? 0 : i + 1;
         ex = poly_x[j] - poly_x[i];
         ey = poly_y[j] - poly_y[i];
         av = ex * (ay - poly_y[i]) - ey * (ax - poly_x[i]);
         bv = ex * dy - ey * dx;
         if (!mid_strictly_inside(av, bv, lo + hi)) return 0;
      end
      return 1;
   endfunction

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         poly_count <= 0;
         bb_min_x <= COORD_TOP;
         bb_min_y <= COORD_TOP;
         bb_max_x <= COORD_BOTTOM;
         bb_max_y <= COORD_BOTTOM;
         hit_answers.delete();
         fail_count <= 0;
      end else begin
         // compare result with oldest prediction
         if (rsp_valid) begin
            if (hit_answers.size() == 0) begin
               $error("unexpected result: hits_interior=%0d", rsp_hits_interior);
               fail_count <= fail_count + 1;
            end else begin
               want = hit_answers.pop_front();
               if (rsp_hits_interior !== want) begin
                  $error("hits_interior: expected %0d, actual %0d", want,
                         rsp_hits_interior);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // track accepted transaction
         if (start && !busy) begin
            case (scph_pkg::opcode_type'(req_opcode))
               scph_pkg::OP_CLEAR: begin
                  poly_count <= 0;
                  bb_min_x <= COORD_TOP;
                  bb_min_y <= COORD_TOP;
                  bb_max_x <= COORD_BOTTOM;
                  bb_max_y <= COORD_BOTTOM;
               end
               scph_pkg::OP_APPEND: begin
                  if (poly_count < CORNER_MAX) begin
                     poly_x[poly_count] <= req_first_x;
                     poly_y[poly_count] <= req_first_y;
                     poly_count <= poly_count + 1;
                     if (req_first_x < bb_min_x) bb_min_x <= req_first_x;
                     if (req_first_x > bb_max_x) bb_max_x <= req_first_x;
                     if (req_first_y < bb_min_y) bb_min_y <= req_first_y;
                     if (req_first_y > bb_max_y) bb_max_y <= req_first_y;
                  end
               end
               scph_pkg::OP_QUERY: hit_answers = {hit_answers,
                                                  segment_hits(req_first_x, req_first_y,
                                                               req_second_x, req_second_y)};
               default: ;
            endcase
         end
      end
      // publish the number of outstanding answers
      pending_count <= hit_answers.size();
   end
endmodule

// ===== test/tb.sv =====
// Testbench top for segment_convex_polygon_hit: drives polygon loads and
// segment queries with random gaps and gives the verdict.
// Depends on scph_pkg, the block and scph_checker.
`timescale 1ns / 1ps
module tb;

   localparam int STALL_LIMIT = 20000;

   logic clock, reset, start, busy, rsp_valid, rsp_hits_interior;
   logic [1:0] req_opcode;
   logic signed [23:0] req_first_x, req_first_y, req_second_x, req_second_y;
   int fail_count, pending_count, idle_cycles, sent;

   segment_convex_polygon_hit uut (.*);

   scph_checker chk (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // watchdog on cycles with no accepted transaction and no result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // hand one transaction over, then hold off a random gap
   task automatic send(scph_pkg::opcode_type op, int fx, int fy, int sx, int sy);
      int gap;
      req_opcode <= op;
      req_first_x <= 24'(fx);
      req_first_y <= 24'(fy);
      req_second_x <= 24'(sx);
      req_second_y <= 24'(sy);
      start <= 1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent++;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic int any_coord();
      return int'($signed(24'($urandom())));
   endfunction

   // random convex polygon: points on a scaled, shifted circle, CCW order
   task automatic load_polygon(int corners, int scale);
      int cx, cy;
      real ang;
      cx = $urandom_range(0, 1) ? 0 : int'($signed(24'($urandom()))) / 4;
      cy = $urandom_range(0, 1) ? 0 : int'($signed(24'($urandom()))) / 4;
      send(scph_pkg::OP_CLEAR, any_coord(), any_coord(), any_coord(), any_coord());
      for (int i = 0; i < corners; i++) begin
         ang = 6.2831853 * (i + $urandom_range(0, 80) / 100.0) / corners;
         send(scph_pkg::OP_APPEND, cx + int'(scale * $cos(ang)),
              cy + int'(scale * $sin(ang)), any_coord(), any_coord());
      end
   endtask

   function automatic int near(int scale);
      return int'($urandom_range(0, 2 * scale * 3)) - scale * 3;
   endfunction

   initial begin
      int scale;
      reset = 1;
      start = 0;
      req_opcode = scph_pkg::OP_NOP;
      req_first_x = 0;
      req_first_y = 0;
      req_second_x = 0;
      req_second_y = 0;
      sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty polygon, too few corners, nop
      send(scph_pkg::OP_QUERY, 0, 0, 5, 5);
      send(scph_pkg::OP_APPEND, 0, 0, 0, 0);
      send(scph_pkg::OP_APPEND, 10, 0, 0, 0);
      send(scph_pkg::OP_QUERY, -1, 1, 20, 1);
      send(scph_pkg::OP_NOP, -1, -1, -1, -1);
      // square with edges hitting corner and parallel cases
      send(scph_pkg::OP_APPEND, 10, 10, 0, 0);
      send(scph_pkg::OP_APPEND, 0, 10, 0, 0);
      send(scph_pkg::OP_QUERY, -5, 5, 15, 5);
      send(scph_pkg::OP_QUERY, -5, 0, 15, 0);
      send(scph_pkg::OP_QUERY, -5, 10, 15, 10);
      send(scph_pkg::OP_QUERY, 5, 5, 5, 5);
      send(scph_pkg::OP_QUERY, 0, 0, 10, 10);
      send(scph_pkg::OP_QUERY, -8388608, -8388608, 8388607, 8388607);
      send(scph_pkg::OP_QUERY, 8388607, -8388608, -8388608, 8388607);
      send(scph_pkg::OP_QUERY, 20, 20, 30, 30);
      // extreme-corner triangle plus overflow of the corner store
      send(scph_pkg::OP_CLEAR, 0, 0, 0, 0);
      send(scph_pkg::OP_APPEND, -8388608, -8388608, 0, 0);
      send(scph_pkg::OP_APPEND, 8388607, -8388608, 0, 0);
      send(scph_pkg::OP_APPEND, 8388607, 8388607, 0, 0);
      send(scph_pkg::OP_QUERY, -8388608, 8388607, 8388607, -8388608);
      send(scph_pkg::OP_QUERY, 8388607, 8388607, -8388608, -8388608);
      for (int i = 0; i < 14; i++) send(scph_pkg::OP_APPEND, 8388607 - i, 8388607, 0, 0);
      send(scph_pkg::OP_QUERY, 0, -100, 0, 100);

      // hold off until every answer is in
      start <= 0;
      wait (pending_count == 0);
      @(negedge clock);

      // random: convex polygons with queries around them, some noise
      while (sent < 1300) begin
         case ($urandom_range(0, 9))
            0: scale = $urandom_range(1, 20);
            1: scale = 4000000;
            default: scale = $urandom_range(10, 100000);
         endcase
         load_polygon($urandom_range(0, 9) == 0 ? $urandom_range(0, 18)
                                               : $urandom_range(3, 16), scale);
         repeat ($urandom_range(3, 12)) begin
            case ($urandom_range(0, 9))
               0: send(scph_pkg::OP_QUERY, any_coord(), any_coord(), any_coord(),
                       any_coord());
               1: send(scph_pkg::opcode_type'($urandom_range(0, 3)), any_coord(),
                       any_coord(), any_coord(), any_coord());
               default: send(scph_pkg::OP_QUERY, int'(chk.bb_min_x + near(scale) / 2),
                             int'(chk.bb_min_y + near(scale) / 2),
                             int'(chk.bb_min_x + near(scale)),
                             int'(chk.bb_min_y + near(scale)));
            endcase
         end
      end

      start <= 0;
      wait (pending_count == 0);
      repeat (2000) @(posedge clock);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
